### hdl/scm_pkg.sv
package scm_pkg;

  localparam int MAX_FEATURES = 64;
  localparam int MAX_SAMPLES = 1024;

  localparam int FEATURE_COUNT_W = 7;
  localparam int SAMPLE_COUNT_W = 11;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_INDEX_W = 1;

  localparam int KIND_W = 2;
  localparam int VALUE_W = 8;
  localparam int INDEX_W = 6;
  localparam int COV_W = 24;
  localparam int STATUS_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_FEATURE_COUNT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_COUNT = 1'd1;

  localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_INCOMPLETE = 2'd2;

  localparam logic [FEATURE_COUNT_W-1:0] FEATURE_COUNT_RESET = 7'd64;
  localparam logic [SAMPLE_COUNT_W-1:0] SAMPLE_COUNT_RESET = 11'd1024;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [VALUE_W-1:0] sample_value;
    logic [INDEX_W-1:0] first_feature;
    logic [INDEX_W-1:0] second_feature;
  } request_t;

  typedef struct packed {
    logic signed [COV_W-1:0] covariance;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

### hdl/scm_if.sv
interface scm_req_if;
  logic valid;
  logic ready;
  scm_pkg::request_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface scm_res_if;
  logic valid;
  logic ready;
  scm_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/scm_ram.sv
module scm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

### hdl/sample_covariance_matrix.sv
// Sample covariance engine. Load transfers fill an N by M matrix of bytes in row-major
// order, one per cycle while idle and no result waits. A read uses an 8x8 multiplier
// for the dot product and adders for both row sums, over two reads of the sample
// memory per sample (single read port, states S_RD_A, S_RD_B, S_MAC), then product
// steps S_PROD1 and S_PROD2, a restoring divider yielding one quotient bit per cycle,
// 48 bits in all, and a sign step. Clear transfers and any register write restart
// loading. Reads with an index >= N give status 1, reads before the load is complete
// give status 2, both with a zero covariance and in the cycle after the transfer.
module sample_covariance_matrix #(
  parameter int MAX_FEATURES = scm_pkg::MAX_FEATURES,
  parameter int MAX_SAMPLES = scm_pkg::MAX_SAMPLES
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [scm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [scm_pkg::CFG_DATA_W-1:0]   cfg_data,
  scm_req_if.sink                          req,
  scm_res_if.source                        res
);
  localparam int ROW_W = $clog2(MAX_FEATURES);
  localparam int COL_W = $clog2(MAX_SAMPLES);
  localparam int DEPTH = MAX_FEATURES * MAX_SAMPLES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int POS_W = ADDR_W + 1;
  localparam int SUM_W = 18;
  localparam int PROD_W = 2 * scm_pkg::VALUE_W;
  localparam int DOT_W = 2 * scm_pkg::VALUE_W + COL_W + 1;
  localparam int PM_W = DOT_W + COL_W + 1;
  localparam int PS_W = 2 * SUM_W;
  localparam int NUM_W = 48;
  localparam int DEN_W = 2 * (COL_W + 1);
  localparam int QBITS = NUM_W;
  localparam int QCNT_W = $clog2(QBITS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RD_A, S_RD_B, S_MAC, S_PROD1, S_PROD2, S_DIV, S_SIGN, S_OUT
  } state_t;

  state_t state;
  logic [scm_pkg::FEATURE_COUNT_W-1:0] feature_count;
  logic [scm_pkg::SAMPLE_COUNT_W-1:0] sample_count;
  logic [POS_W-1:0] load_position;

  logic [ROW_W:0] n_used;
  logic [COL_W:0] m_used;
  logic [POS_W+ROW_W:0] total;
  logic load_done;

  logic [COL_W:0] k;
  logic [ADDR_W-1:0] base_a, base_b;
  logic [scm_pkg::VALUE_W-1:0] a_val;
  logic [DOT_W-1:0] dot;
  logic [SUM_W-1:0] sum_a, sum_b;
  logic signed [NUM_W-1:0] prod_m, prod_s;
  logic [NUM_W-1:0] quo, rem_mag;
  logic [DEN_W-1:0] den;
  logic neg;
  logic [QCNT_W-1:0] qcnt;
  logic mem_phase_b;

  logic ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [scm_pkg::VALUE_W-1:0] ram_rdata;

  scm_pkg::result_t out_reg;
  logic out_valid;

  always_comb begin
    if (feature_count == '0) begin
      n_used = (ROW_W+1)'(1);
    end else if (32'(feature_count) > MAX_FEATURES) begin
      n_used = (ROW_W+1)'(MAX_FEATURES);
    end else begin
      n_used = (ROW_W+1)'(feature_count);
    end
    if (sample_count < 11'd2) begin
      m_used = (COL_W+1)'(2);
    end else if (32'(sample_count) > MAX_SAMPLES) begin
      m_used = (COL_W+1)'(MAX_SAMPLES);
    end else begin
      m_used = (COL_W+1)'(sample_count);
    end
  end

  assign total = (POS_W+ROW_W+1)'(n_used) * (POS_W+ROW_W+1)'(m_used);
  assign load_done = (POS_W+ROW_W+1)'(load_position) >= total;

  assign ram_we = (state == S_IDLE) && req.valid && req.ready
                  && req.data.kind == scm_pkg::KIND_LOAD && !load_done;
  assign ram_waddr = load_position[ADDR_W-1:0];
  assign ram_raddr = mem_phase_b ? base_b + ADDR_W'(k) : base_a + ADDR_W'(k);

  scm_ram #(.WIDTH(scm_pkg::VALUE_W), .DEPTH(DEPTH)) u_store (
    .clk(clk), .wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(req.data.sample_value),
    .rd_addr(ram_raddr), .rd_data(ram_rdata)
  );

  assign req.ready = (state == S_IDLE) && !out_valid;
  assign res.valid = out_valid;
  assign res.data = out_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      feature_count <= scm_pkg::FEATURE_COUNT_RESET;
      sample_count <= scm_pkg::SAMPLE_COUNT_RESET;
      load_position <= '0;
      out_valid <= 1'b0;
      mem_phase_b <= 1'b0;
    end else begin
      if (out_valid && res.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          scm_pkg::REG_FEATURE_COUNT: feature_count <= cfg_data[scm_pkg::FEATURE_COUNT_W-1:0];
          scm_pkg::REG_SAMPLE_COUNT: sample_count <= cfg_data;
          default: ;
        endcase
        load_position <= '0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            unique case (req.data.kind)
              scm_pkg::KIND_LOAD: begin
                if (!load_done) begin
                  load_position <= load_position + 1'b1;
                end
              end
              scm_pkg::KIND_CLEAR: begin
                load_position <= '0;
              end
              scm_pkg::KIND_READ: begin
                out_reg.covariance <= '0;
                if ((ROW_W+1)'(req.data.first_feature) >= n_used
                    || (ROW_W+1)'(req.data.second_feature) >= n_used
                    || 32'(req.data.first_feature) >= MAX_FEATURES
                    || 32'(req.data.second_feature) >= MAX_FEATURES) begin
                  out_reg.status <= scm_pkg::STATUS_RANGE;
                  out_valid <= 1'b1;
                end else if (!load_done) begin
                  out_reg.status <= scm_pkg::STATUS_INCOMPLETE;
                  out_valid <= 1'b1;
                end else begin
                  out_reg.status <= scm_pkg::STATUS_OK;
                  base_a <= ADDR_W'(req.data.first_feature) * ADDR_W'(m_used);
                  base_b <= ADDR_W'(req.data.second_feature) * ADDR_W'(m_used);
                  den <= DEN_W'(m_used) * DEN_W'(m_used - 1'b1);
                  k <= '0;
                  dot <= '0;
                  sum_a <= '0;
                  sum_b <= '0;
                  mem_phase_b <= 1'b0;
                  state <= S_RD_A;
                end
              end
              default: ;
            endcase
          end
        end
        S_RD_A: begin
          mem_phase_b <= 1'b1;
          state <= S_RD_B;
        end
        S_RD_B: begin
          a_val <= ram_rdata;
          mem_phase_b <= 1'b0;
          state <= S_MAC;
        end
        S_MAC: begin
          dot <= dot + DOT_W'(PROD_W'(a_val) * PROD_W'(ram_rdata));
          sum_a <= sum_a + SUM_W'(a_val);
          sum_b <= sum_b + SUM_W'(ram_rdata);
          if (k == m_used - 1'b1) begin
            state <= S_PROD1;
          end else begin
            k <= k + 1'b1;
            state <= S_RD_A;
          end
        end
        S_PROD1: begin
          prod_m <= signed'(NUM_W'(PM_W'(dot) * PM_W'(m_used)));
          prod_s <= signed'(NUM_W'(PS_W'(sum_a) * PS_W'(sum_b)));
          state <= S_PROD2;
        end
        S_PROD2: begin
          neg <= prod_m < prod_s;
          quo <= (prod_m < prod_s) ? NUM_W'((prod_s - prod_m) <<< 8)
                                   : NUM_W'((prod_m - prod_s) <<< 8);
          rem_mag <= '0;
          qcnt <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if ({rem_mag[NUM_W-2:0], quo[NUM_W-1]} >= NUM_W'(den)) begin
            rem_mag <= {rem_mag[NUM_W-2:0], quo[NUM_W-1]} - NUM_W'(den);
            quo <= {quo[NUM_W-2:0], 1'b1};
          end else begin
            rem_mag <= {rem_mag[NUM_W-2:0], quo[NUM_W-1]};
            quo <= {quo[NUM_W-2:0], 1'b0};
          end
          if (qcnt == QCNT_W'(QBITS - 1)) begin
            state <= S_SIGN;
          end else begin
            qcnt <= qcnt + 1'b1;
          end
        end
        S_SIGN: begin
          out_reg.covariance <= neg ? -quo[scm_pkg::COV_W-1:0] : quo[scm_pkg::COV_W-1:0];
          state <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### hdl/scm_checker.sv
module scm_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic res_valid,
  input logic res_ready,
  input logic [scm_pkg::STATUS_W-1:0] res_status,
  input logic [scm_pkg::COV_W-1:0] res_covariance
);
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_status))
    else $error("Result changed while stalled.");
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status != scm_pkg::STATUS_OK |-> res_covariance == '0)
    else $error("Error result carries a nonzero covariance.");
  a_no_accept_while_out: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !req_ready)
    else $error("Input taken while a result waits.");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_status <= scm_pkg::STATUS_INCOMPLETE)
    else $error("Undefined status code.");
endmodule

bind sample_covariance_matrix scm_checker u_scm_checker (
  .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
  .res_valid(res.valid), .res_ready(res.ready), .res_status(res.data.status),
  .res_covariance(res.data.covariance)
);
